FILE: rtl/ascm_pkg.sv
// ----------------------------------------------------------------------------
// ascm_pkg
// Types and constants shared by the sample convergence monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ascm_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int COUNT_W    = 16;
	localparam int SUM_W      = 48;
	localparam int MEAN_W     = 48;
	localparam int M2_W       = 64;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int EXT_BITS   = 16;
	localparam int ACC_W      = 176;
	localparam int BITS_W     = 6;

	localparam int DEF_MIN_CHECK_SAMPLES = 32;
	localparam int DEF_ZERO_VAR_SAMPLES  = 64;
	localparam int DEF_FRAC_BITS         = 16;

	localparam logic [COUNT_W-1:0] REL_MARGIN = 16'd4;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

	localparam logic [CFG_W-1:0] RST_MAX_SAMPLES = 16'd64;
	localparam logic [CFG_W-1:0] RST_THRESHOLD   = 16'd655;
	localparam logic [CFG_W-1:0] RST_NEAR_ZERO   = 16'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ADAPTIVE  = 8'd0,
		REG_MAX_SAMP  = 8'd1,
		REG_THRESHOLD = 8'd2,
		REG_NEAR_ZERO = 8'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WDIV,
		ST_WUPD,
		ST_WMUL,
		ST_WACC,
		ST_TEST,
		ST_TMUL,
		ST_TNEXT,
		ST_CHK,
		ST_ODIV,
		ST_OSTORE,
		ST_OUT
	} state_t;

	// Step of the convergence product chain, and channel of the mean divisions
	typedef enum logic [2:0] {
		OP_MEAN_SQ,
		OP_THR_A,
		OP_THR_B,
		OP_MARGIN_A,
		OP_MARGIN_B,
		OP_NM1,
		OP_LHS
	} op_t;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

endpackage

`default_nettype wire

FILE: rtl/adaptive_sample_convergence_monitor.sv
// ----------------------------------------------------------------------------
// adaptive_sample_convergence_monitor
// Per-pixel sample accumulator with Welford luminance variance and a
// relative standard error convergence test.
// ----------------------------------------------------------------------------
// Work per item: the Welford update when adaptive mode is on, the relative
//   test when it applies, and the three mean divisions when the pixel is done.
// Throughput: one item at a time; s_tready is high only while idle. The cost
//   is set by the bit-serial divider and the bit-serial
//   multiplier (one multiplier bit a cycle) that all steps share.
// Reset: arst_n clears the accumulators, the sequencer and the output register
//   at once and loads the configuration registers with their defaults.
`default_nettype none

module adaptive_sample_convergence_monitor
	import ascm_pkg::*;
#(
	parameter int MIN_CHECK_SAMPLES = DEF_MIN_CHECK_SAMPLES,
	parameter int ZERO_VAR_SAMPLES  = DEF_ZERO_VAR_SAMPLES,
	parameter int FRAC_BITS         = DEF_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// sample items
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [95:0]          s_tdata,   // sample_red, sample_green, sample_blue
	input  wire logic                 s_tuser,   // start_pixel
	input  wire logic                 s_tlast,   // batch_end
	// result items
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [111:0]              m_tdata,   // sample_count, mean_red, mean_green, mean_blue
	output logic                      m_tuser,   // converged
	output logic                      m_tlast,   // pixel_done
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam logic [COUNT_W-1:0] MIN_CHECK = COUNT_W'(MIN_CHECK_SAMPLES);
	localparam logic [COUNT_W-1:0] ZERO_VAR  = COUNT_W'(ZERO_VAR_SAMPLES);
	localparam logic [BITS_W-1:0]  DIV_STEPS = BITS_W'(SUM_W);
	localparam logic [BITS_W-1:0]  NARROW    = BITS_W'(COUNT_W);

	state_t state_q, state_d;

	// configuration
	logic               adaptive_q;
	logic [CFG_W-1:0]   max_q, thr_q, nz_q;

	// pixel state
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_r_q, sum_g_q, sum_b_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [M2_W-1:0]    m2_q;
	logic               conv_q;

	// item in flight
	logic [SAMPLE_W-1:0] lum_q;
	logic                batch_q, neg_q, done_q;
	logic [MEAN_W-1:0]   d_q;

	// shared divider and multiplier
	logic [SUM_W-1:0]   div_d_q;
	logic [COUNT_W-1:0] div_v_q, div_rem_q;
	logic [ACC_W-1:0]   mc_q, acc_q, rhs_q;
	logic [MEAN_W-1:0]  mx_q;
	logic [BITS_W-1:0]  bits_q;
	op_t                op_q;
	chan_t              ch_q;
	logic [SAMPLE_W-1:0] mr_q, mg_q, mb_q;

	// output register
	logic               out_valid_q, out_conv_q, out_done_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic [SAMPLE_W-1:0] out_r_q, out_g_q, out_b_q;

	// combinational helpers
	logic                accept;
	logic [SAMPLE_W-1:0] in_r, in_g, in_b, lum_in;
	logic [COUNT_W-1:0]  cnt_base;
	logic [MEAN_W-1:0]   mean_base, ext_in, ext_q, mean_new, d2;
	logic [COUNT_W:0]    div_t, div_sub;
	logic                div_ge;
	logic [ACC_W-1:0]    mul_next, lhs;
	logic [M2_W:0]       m2_sum;
	logic                test_go, rel_path;
	logic                out_load;

	assign in_r = s_tdata[31:0];
	assign in_g = s_tdata[63:32];
	assign in_b = s_tdata[95:64];

	always_comb begin
		lum_in = in_r;
		if (in_g > lum_in) lum_in = in_g;
		if (in_b > lum_in) lum_in = in_b;
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	assign cnt_base  = s_tuser ? '0 : count_q;
	assign mean_base = s_tuser ? '0 : mean_q;
	assign ext_in    = {lum_in, {EXT_BITS{1'b0}}};
	assign ext_q     = {lum_q, {EXT_BITS{1'b0}}};

	// restoring division step: one quotient bit a cycle
	assign div_t   = {div_rem_q, div_d_q[SUM_W-1]};
	assign div_ge  = div_t >= {1'b0, div_v_q};
	assign div_sub = div_t - {1'b0, div_v_q};

	// shift-add multiply step, multiplier MSB first
	assign mul_next = {acc_q[ACC_W-2:0], 1'b0} + (mx_q[MEAN_W-1] ? mc_q : '0);

	// Welford mean update from the finished quotient
	assign mean_new = neg_q ? (mean_q - div_d_q) : (mean_q + div_d_q);
	assign d2       = neg_q ? (mean_new - ext_q) : (ext_q - mean_new);

	assign m2_sum = {1'b0, m2_q} + {1'b0, acc_q[M2_W+31:32]};
	assign lhs    = {acc_q[ACC_W-65:0], 64'd0};

	assign test_go  = batch_q && adaptive_q && (count_q >= MIN_CHECK) && (count_q >= 16'd2);
	assign rel_path = mean_q > {16'd0, nz_q, {EXT_BITS{1'b0}}};

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = (cnt_base != COUNT_MAX && adaptive_q) ? ST_WDIV : ST_TEST;
			end
			ST_WDIV:   if (bits_q == 1) state_d = ST_WUPD;
			ST_WUPD:   state_d = ST_WMUL;
			ST_WMUL:   if (bits_q == 1) state_d = ST_WACC;
			ST_WACC:   state_d = ST_TEST;
			ST_TEST: begin
				if (test_go && rel_path && count_q > REL_MARGIN)
					state_d = ST_TMUL;
				else
					state_d = ST_CHK;
			end
			ST_TMUL:   if (bits_q == 1) state_d = ST_TNEXT;
			ST_TNEXT:  state_d = (op_q == OP_LHS) ? ST_CHK : ST_TMUL;
			ST_CHK:    state_d = (conv_q || count_q >= max_q) ? ST_ODIV : ST_OUT;
			ST_ODIV:   if (bits_q == 1) state_d = ST_OSTORE;
			ST_OSTORE: state_d = (ch_q == CH_BLUE) ? ST_OUT : ST_ODIV;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adaptive_q <= 1'b1;
			max_q      <= RST_MAX_SAMPLES;
			thr_q      <= RST_THRESHOLD;
			nz_q       <= RST_NEAR_ZERO;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ADAPTIVE:  adaptive_q <= cfg_data[0];
				REG_MAX_SAMP:  max_q      <= cfg_data;
				REG_THRESHOLD: thr_q      <= cfg_data;
				REG_NEAR_ZERO: nz_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// pixel state: clear on start_pixel, accumulate, Welford and test results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
			conv_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (s_tuser) begin
					mean_q <= '0;
					m2_q   <= '0;
					conv_q <= 1'b0;
				end
				if (cnt_base != COUNT_MAX) begin
					count_q <= cnt_base + 16'd1;
					sum_r_q <= (s_tuser ? '0 : sum_r_q) + SUM_W'(in_r);
					sum_g_q <= (s_tuser ? '0 : sum_g_q) + SUM_W'(in_g);
					sum_b_q <= (s_tuser ? '0 : sum_b_q) + SUM_W'(in_b);
				end else begin
					count_q <= cnt_base;
					if (s_tuser) begin
						sum_r_q <= '0;
						sum_g_q <= '0;
						sum_b_q <= '0;
					end
				end
			end
			if (state_q == ST_WUPD)
				mean_q <= mean_new;
			// saturate M2 at all ones
			if (state_q == ST_WACC)
				m2_q <= m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
			if (state_q == ST_TEST && test_go && !rel_path &&
				m2_q < (M2_W'(nz_q) << FRAC_BITS) && count_q >= ZERO_VAR)
				conv_q <= 1'b1;
			if (state_q == ST_TNEXT && op_q == OP_LHS && lhs < rhs_q)
				conv_q <= 1'b1;
		end
	end

	// item context and shared arithmetic units
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				// hold the item and load the divider with |L - mean| / n
				lum_q     <= lum_in;
				batch_q   <= s_tlast;
				neg_q     <= ext_in < mean_base;
				d_q       <= (ext_in < mean_base) ? mean_base - ext_in : ext_in - mean_base;
				div_d_q   <= (ext_in < mean_base) ? mean_base - ext_in : ext_in - mean_base;
				div_v_q   <= cnt_base + 16'd1;
				div_rem_q <= '0;
				bits_q    <= DIV_STEPS;
			end
			ST_WDIV, ST_ODIV: begin
				div_d_q   <= {div_d_q[SUM_W-2:0], div_ge};
				div_rem_q <= div_ge ? div_sub[COUNT_W-1:0] : div_t[COUNT_W-1:0];
				bits_q    <= bits_q - 1'b1;
			end
			ST_WUPD: begin
				mc_q   <= ACC_W'(d_q);
				mx_q   <= d2;
				acc_q  <= '0;
				bits_q <= DIV_STEPS;
			end
			ST_WMUL, ST_TMUL: begin
				acc_q  <= mul_next;
				mx_q   <= {mx_q[MEAN_W-2:0], 1'b0};
				bits_q <= bits_q - 1'b1;
			end
			ST_TEST: begin
				mc_q   <= ACC_W'(mean_q);
				mx_q   <= mean_q;
				acc_q  <= '0;
				bits_q <= DIV_STEPS;
				op_q   <= OP_MEAN_SQ;
			end
			ST_TNEXT: begin
				// chain: mean^2 * thr * thr * (n-4) * (n-4) * (n-1), then M2 * n
				mc_q   <= acc_q;
				acc_q  <= '0;
				bits_q <= NARROW;
				unique case (op_q)
					OP_MEAN_SQ: begin
						mx_q <= {thr_q, 32'd0};
						op_q <= OP_THR_A;
					end
					OP_THR_A: begin
						mx_q <= {thr_q, 32'd0};
						op_q <= OP_THR_B;
					end
					OP_THR_B: begin
						mx_q <= {count_q - REL_MARGIN, 32'd0};
						op_q <= OP_MARGIN_A;
					end
					OP_MARGIN_A: begin
						mx_q <= {count_q - REL_MARGIN, 32'd0};
						op_q <= OP_MARGIN_B;
					end
					OP_MARGIN_B: begin
						mx_q <= {count_q - 16'd1, 32'd0};
						op_q <= OP_NM1;
					end
					OP_NM1: begin
						rhs_q <= acc_q;
						mc_q  <= ACC_W'(m2_q);
						mx_q  <= {count_q, 32'd0};
						op_q  <= OP_LHS;
					end
					OP_LHS: ;
					default: ;
				endcase
			end
			ST_CHK: begin
				done_q    <= conv_q || count_q >= max_q;
				mr_q      <= '0;
				mg_q      <= '0;
				mb_q      <= '0;
				div_d_q   <= sum_r_q;
				div_v_q   <= count_q;
				div_rem_q <= '0;
				bits_q    <= DIV_STEPS;
				ch_q      <= CH_RED;
			end
			ST_OSTORE: begin
				// keep the low 32 quotient bits and, after red or green, start the next channel
				unique case (ch_q)
					CH_RED: begin
						mr_q    <= div_d_q[SAMPLE_W-1:0];
						div_d_q <= sum_g_q;
						ch_q    <= CH_GREEN;
					end
					CH_GREEN: begin
						mg_q    <= div_d_q[SAMPLE_W-1:0];
						div_d_q <= sum_b_q;
						ch_q    <= CH_BLUE;
					end
					CH_BLUE:  mb_q <= div_d_q[SAMPLE_W-1:0];
					default: ;
				endcase
				div_rem_q <= '0;
				bits_q    <= DIV_STEPS;
			end
			default: ;
		endcase
	end

	// output register parts the sequencer from the result channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_conv_q <= conv_q;
			out_done_q <= done_q;
			out_cnt_q  <= count_q;
			out_r_q    <= mr_q;
			out_g_q    <= mg_q;
			out_b_q    <= mb_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_b_q, out_g_q, out_r_q, out_cnt_q};
	assign m_tuser  = out_conv_q;
	assign m_tlast  = out_done_q;

`ifndef NO_ASSERTIONS
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser |=> count_q == 16'd1)
		else $error("start_pixel did not restart the sample count");

	a_conv_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		conv_q && !(accept && s_tuser) |=> conv_q)
		else $error("converged flag dropped within a pixel");

	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("converged result not marked done");

	a_busy_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WDIV || state_q == ST_ODIV || state_q == ST_WMUL ||
		 state_q == ST_TMUL) |-> bits_q != '0)
		else $error("serial unit ran past its last step");
`endif

endmodule

`default_nettype wire
